FILE: rtl/tlen_pkg.sv
// Shared types and fixed widths for the tour length evaluator.
`default_nettype none

package tlen_pkg;

  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned LENGTH_W = 27;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TOUR = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } fifo_status_t;

endpackage

`default_nettype wire

FILE: rtl/tlen_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlen_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlen_fifo.sv
// Short queue of visited city coordinates between the front and the back.
`default_nettype none

module tlen_fifo import tlen_pkg::*; #(
  parameter int unsigned DATA_W = 33
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] head,
  output fifo_status_t           status
);

  logic [DATA_W-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LEVEL_W'(1);
      end else if (pop && !push) begin
        level <= level - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (level == '0);
  assign status.level = level;

  // The front must hold back input when a pending read could overflow the queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (level != LEVEL_W'(QUEUE_DEPTH)) || pop)
    else $error("queue pushed while full");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("queue popped while empty");

endmodule

`default_nettype wire

FILE: rtl/tlen_front.sv
// Input side: writes city coordinates and fetches the coordinates of visited cities.
`default_nettype none

module tlen_front import tlen_pkg::*; #(
  parameter int unsigned MAX_CITIES = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    mode,
  input  wire logic [INDEX_W-1:0]      city_index,
  input  wire logic [COORD_W-1:0]      coord_x,
  input  wire logic [COORD_W-1:0]      coord_y,
  input  wire logic                    last_city,
  input  wire fifo_status_t            fifo_stat,
  output logic                         fifo_push,
  output logic [2*COORD_BITS:0]        fifo_data
);

  localparam int unsigned AW = $clog2(MAX_CITIES);

  logic                    accept;
  logic                    index_ok;
  logic [2*COORD_BITS-1:0] rd_data;
  logic                    s1_valid;
  logic                    s1_last;
  logic                    s1_ok;

  assign accept   = in_valid && in_ready;
  assign index_ok = (32'(city_index) < 32'(MAX_CITIES));

  // Room is counted for the fetch still in flight, whose push is not yet in the queue level.
  assign in_ready = (({1'b0, fifo_stat.level} + (LEVEL_W + 1)'(s1_valid))
                     < (LEVEL_W + 1)'(QUEUE_DEPTH));

  tlen_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_CITIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept && (mode == MODE_LOAD) && index_ok),
    .wr_addr (AW'(city_index)),
    .wr_data ({COORD_BITS'(coord_x), COORD_BITS'(coord_y)}),
    .rd_en   (accept && (mode == MODE_TOUR) && index_ok),
    .rd_addr (AW'(city_index)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (mode == MODE_TOUR);
    end
    if (accept) begin
      s1_last <= last_city;
      s1_ok   <= index_ok;
    end
  end

  // A visit beyond the table sees the origin.
  assign fifo_push = s1_valid;
  assign fifo_data = {(s1_ok ? rd_data : '0), s1_last};

endmodule

`default_nettype wire

FILE: rtl/tlen_back.sv
// Edge length sequencer: absolute differences, squares, bitwise square root, running sum.
`default_nettype none

module tlen_back import tlen_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [2*COORD_BITS:0] fifo_head,
  input  wire fifo_status_t         fifo_stat,
  output logic                      fifo_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [LENGTH_W-1:0]       tour_length,
  output logic [COUNT_W-1:0]        city_count
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned R      = CB + 1;
  localparam int unsigned RAD_W  = 2 * R;
  localparam int unsigned REM_W  = R + 3;
  localparam int unsigned STEP_W = $clog2(R + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_MUL, S_LOAD, S_ROOT, S_ADD, S_EMIT
  } state_t;

  state_t              state;
  logic [CB-1:0]       cur_x, cur_y, a_x, a_y;
  logic [CB-1:0]       first_x, first_y, prev_x, prev_y;
  logic                cur_last;
  logic                closing;
  logic [CB-1:0]       dx, dy;
  logic [2*CB-1:0]     sq_x, sq_y;
  logic [RAD_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [R-1:0]        root;
  logic [STEP_W-1:0]   step;
  logic [LENGTH_W-1:0] length_sum;
  logic [COUNT_W-1:0]  visited_count;

  logic [CB-1:0]       head_x, head_y;
  logic                head_last;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    trial;
  logic [LENGTH_W:0]   sum_ext;
  logic [COUNT_W-1:0]  count_inc;
  logic                emit_go;

  assign head_x    = fifo_head[2*CB:CB+1];
  assign head_y    = fifo_head[CB:1];
  assign head_last = fifo_head[0];

  assign fifo_pop  = (state == S_IDLE) && !fifo_stat.empty;

  assign rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign sum_ext   = {1'b0, length_sum} + (LENGTH_W + 1)'(root);
  assign count_inc = (visited_count == COUNT_MAX) ? visited_count
                                                  : visited_count + COUNT_W'(1);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      length_sum    <= '0;
      visited_count <= '0;
      closing       <= 1'b0;
      step          <= '0;
    end else begin
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!fifo_stat.empty) begin
            cur_x    <= head_x;
            cur_y    <= head_y;
            cur_last <= head_last;
            closing  <= 1'b0;
            if (visited_count == '0) begin
              // The first city only opens the tour; a lone city closes at zero length.
              first_x       <= head_x;
              first_y       <= head_y;
              prev_x        <= head_x;
              prev_y        <= head_y;
              visited_count <= count_inc;
              if (head_last) begin
                state <= S_EMIT;
              end
            end else begin
              a_x   <= prev_x;
              a_y   <= prev_y;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          dx    <= (a_x > cur_x) ? a_x - cur_x : cur_x - a_x;
          dy    <= (a_y > cur_y) ? a_y - cur_y : cur_y - a_y;
          state <= S_MUL;
        end
        S_MUL: begin
          sq_x  <= dx * dx;
          sq_y  <= dy * dy;
          state <= S_LOAD;
        end
        S_LOAD: begin
          rad   <= RAD_W'(sq_x) + RAD_W'(sq_y);
          rem   <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (rem_shift >= trial) begin
            rem  <= rem_shift - trial;
            root <= {root[R-2:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            root <= {root[R-2:0], 1'b0};
          end
          rad  <= rad << 2;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(R - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          length_sum <= sum_ext[LENGTH_W] ? '1 : sum_ext[LENGTH_W-1:0];
          if (closing) begin
            state <= S_EMIT;
          end else begin
            prev_x        <= cur_x;
            prev_y        <= cur_y;
            visited_count <= count_inc;
            if (cur_last) begin
              closing <= 1'b1;
              a_x     <= first_x;
              a_y     <= first_y;
              state   <= S_DIFF;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid     <= 1'b1;
            tour_length   <= length_sum;
            city_count    <= visited_count;
            length_sum    <= '0;
            visited_count <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (length_sum == '0) && (visited_count == '0) && out_valid)
    else $error("tour state not cleared after a result");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> (step < STEP_W'(R)))
    else $error("square root ran past its last bit");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result raised outside the emit step");

endmodule

`default_nettype wire

FILE: rtl/tour_length_evaluator_top.sv
// Top level of the tour length evaluator: front end, coordinate queue and edge sequencer.
//
// Load beats (mode 0) write one city's Q12.4 coordinates into the city table. Tour beats
// (mode 1) fetch the named city from the table and queue it; the back end then only records
// the opening city of a tour and, for every later city, takes the difference, the squares,
// and a square root that settles one result bit per cycle, then adds the edge to the sum.
// The beat marked last runs the closing edge as well and then presents tour_length (Q23.4,
// saturating) and city_count. The square root unit is the limit on sustained rate. Up to
// four fetched cities wait in the queue, so loads and fetches keep flowing while the back
// end works until the queue fills, and a finished result waits in its output register
// without stopping the next tour until that tour's own result is ready.
`default_nettype none

module tour_length_evaluator_top import tlen_pkg::*; #(
  parameter int unsigned MAX_CITIES = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic [INDEX_W-1:0]  city_index,
  input  wire logic [COORD_W-1:0]  coord_x,
  input  wire logic [COORD_W-1:0]  coord_y,
  input  wire logic                last_city,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [LENGTH_W-1:0]      tour_length,
  output logic [COUNT_W-1:0]       city_count
);

  localparam int unsigned ENTRY_W = 2 * COORD_BITS + 1;

  fifo_status_t       fifo_stat;
  logic               fifo_push;
  logic               fifo_pop;
  logic [ENTRY_W-1:0] fifo_data;
  logic [ENTRY_W-1:0] fifo_head;

  tlen_front #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .city_index (city_index),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .last_city  (last_city),
    .fifo_stat  (fifo_stat),
    .fifo_push  (fifo_push),
    .fifo_data  (fifo_data)
  );

  tlen_fifo #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_data),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .status    (fifo_stat)
  );

  tlen_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_head   (fifo_head),
    .fifo_stat   (fifo_stat),
    .fifo_pop    (fifo_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tour_length (tour_length),
    .city_count  (city_count)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the tour length evaluator: directed table, random tours, scoreboard.
`default_nettype none

module tb import tlen_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CITIES = 1 << INDEX_W;
  localparam logic [LENGTH_W-1:0] LENGTH_TOP = '1;
  localparam int unsigned GAP_MAX = 18;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned LONG_TOUR = 2100;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned SHOWN_MAX = 10;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic [COUNT_W-1:0]  count;
  } tour_t;

  typedef struct packed {
    beat_t beat;
    logic  typed;
    tour_t result;
  } step_t;

  localparam tour_t NO_TOUR = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = MODE_LOAD;
  logic [INDEX_W-1:0]  city_index = '0;
  logic [COORD_W-1:0]  coord_x = '0;
  logic [COORD_W-1:0]  coord_y = '0;
  logic                last_city = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LENGTH_W-1:0] tour_length;
  logic [COUNT_W-1:0]  city_count;

  tour_t expected_tours[$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned tours_taken = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  // Mirror of the city table and of the running tour.
  bit [COORD_W-1:0]  city_x [CITIES];
  bit [COORD_W-1:0]  city_y [CITIES];
  bit                loaded [CITIES];
  int unsigned       loaded_list[$];
  bit [COORD_W-1:0]  origin_x, origin_y, prev_x, prev_y;
  bit [LENGTH_W-1:0] length_acc;
  bit [COUNT_W-1:0]  count_acc;

  // Directed beats; a typed result is one worked out by hand.
  step_t plan [24] = '{
    '{'{MODE_LOAD, 10'd0,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_LOAD, 10'd1023, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_LOAD, 10'd512,  16'hFFFF, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_LOAD, 10'd5,    16'h1234, 16'h0ABC, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_LOAD, 10'd6,    16'h0030, 16'h0040, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd0,    16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, '{27'd0, 11'd1}},
    '{'{MODE_TOUR, 10'd0,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd1023, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd185360, 11'd2}},
    '{'{MODE_TOUR, 10'd0,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd512,  16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd131070, 11'd2}},
    '{'{MODE_TOUR, 10'd0,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_LOAD, 10'd7,    16'h0060, 16'h0080, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd6,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd7,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd5,    16'h0000, 16'h0000, 1'b1}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd1023, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd1023, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd0, 11'd2}},
    '{'{MODE_TOUR, 10'd6,    16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd0,    16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd160, 11'd2}},
    '{'{MODE_LOAD, 10'd8,    16'h7FFF, 16'h8000, 1'b1}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd8,    16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd0, 11'd1}},
    '{'{MODE_TOUR, 10'd1023, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd512,  16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TOUR},
    '{'{MODE_TOUR, 10'd0,    16'h0000, 16'h0000, 1'b1}, 1'b1, '{27'd223750, 11'd3}}
  };

  tour_length_evaluator_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .city_index  (city_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .last_city   (last_city),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tour_length (tour_length),
    .city_count  (city_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned edge_length(bit [COORD_W-1:0] ax, bit [COORD_W-1:0] ay,
                                                 bit [COORD_W-1:0] bx, bit [COORD_W-1:0] by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return floor_root(dx * dx + dy * dy);
  endfunction

  function automatic void add_edge(longint unsigned d);
    longint unsigned total;
    total = length_acc + d;
    length_acc = (total > LENGTH_TOP) ? LENGTH_TOP : total[LENGTH_W-1:0];
  endfunction

  // Advances the mirrored state by one beat; returns 1 when the beat closes a tour.
  function automatic bit close_tour(input beat_t b, output tour_t r);
    bit [COORD_W-1:0] cx;
    bit [COORD_W-1:0] cy;
    r = '0;
    if (b.mode == MODE_LOAD) begin
      city_x[b.index] = b.x;
      city_y[b.index] = b.y;
      if (!loaded[b.index]) begin
        loaded[b.index] = 1'b1;
        loaded_list.push_back(b.index);
      end
      return 1'b0;
    end
    cx = city_x[b.index];
    cy = city_y[b.index];
    if (count_acc == 0) begin
      origin_x = cx;
      origin_y = cy;
    end else begin
      add_edge(edge_length(prev_x, prev_y, cx, cy));
    end
    prev_x = cx;
    prev_y = cy;
    if (count_acc != COUNT_MAX) count_acc++;
    if (!b.last) return 1'b0;
    add_edge(edge_length(cx, cy, origin_x, origin_y));
    r.length = length_acc;
    r.count = count_acc;
    length_acc = '0;
    count_acc = '0;
    origin_x = '0;
    origin_y = '0;
    prev_x = '0;
    prev_y = '0;
    return 1'b1;
  endfunction

  function automatic bit [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input tour_t typed_result);
    int unsigned gap;
    tour_t r;
    if (beats_sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= b.mode;
    city_index <= b.index;
    coord_x <= b.x;
    coord_y <= b.y;
    last_city <= b.last;
    do @(posedge clk); while (in_ready !== 1'b1);
    beats_sent++;
    if (close_tour(b, r)) expected_tours.push_back(typed ? typed_result : r);
  endtask

  task automatic send_load();
    beat_t b;
    b.mode = MODE_LOAD;
    b.index = INDEX_W'($urandom);
    b.x = pick_coord();
    b.y = pick_coord();
    b.last = 1'(($urandom_range(0, 3) == 0));
    send_beat(b, 1'b0, NO_TOUR);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tours.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned hops;
    beat_t b;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].result);
    wait_idle();

    // Mostly well-formed tours over loaded cities, with load bursts and the odd
    // tour whose last mark is dropped so it runs on into the next one.
    while (beats_sent < $size(plan) + RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 2 || loaded_list.size() < 16) begin
        repeat ($urandom_range(1, 6)) send_load();
      end else begin
        hops = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (int h = 0; h < hops; h++) begin
          if ($urandom_range(0, 9) == 0) send_load();
          b.mode = MODE_TOUR;
          b.index = INDEX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
          b.x = pick_coord();
          b.y = pick_coord();
          b.last = 1'((h == hops - 1) && ($urandom_range(0, 19) != 0));
          send_beat(b, 1'b0, NO_TOUR);
        end
      end
    end
    b = '{MODE_TOUR, INDEX_W'(loaded_list[0]), '0, '0, 1'b1};
    send_beat(b, 1'b0, NO_TOUR);
    wait_idle();

    // Opposite corners back and forth until both the length and the count saturate.
    send_beat('{MODE_LOAD, INDEX_W'(0), '0, '0, 1'b0}, 1'b0, NO_TOUR);
    send_beat('{MODE_LOAD, INDEX_W'(CITIES - 1), '1, '1, 1'b0}, 1'b0, NO_TOUR);
    for (int h = 0; h < LONG_TOUR; h++) begin
      b = '{MODE_TOUR, (h % 2 == 0) ? INDEX_W'(0) : INDEX_W'(CITIES - 1), '0, '0,
            1'(h == LONG_TOUR - 1)};
      send_beat(b, 1'(h == LONG_TOUR - 1), '{LENGTH_TOP, COUNT_MAX});
    end

    in_valid <= 1'b0;
    while (expected_tours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_tours.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    tour_t got;
    tour_t want;
    while (rst) @(posedge clk);
    forever begin
      if (tours_taken % 8 == 0) take_calm = ($urandom_range(0, 3) == 0);
      stall = take_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tours_taken++;
      got.length = tour_length;
      got.count = city_count;
      if (expected_tours.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MAX)
          $display("unexpected tour beat: length %0d count %0d", got.length, got.count);
      end else begin
        want = expected_tours.pop_front();
        if (got.length !== want.length || got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MAX)
            $display("tour %0d: expected length %0d count %0d, got length %0d count %0d",
                     tours_taken, want.length, want.count, got.length, got.count);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/tlen_pkg.sv
rtl/tlen_ram.sv
rtl/tlen_fifo.sv
rtl/tlen_front.sv
rtl/tlen_back.sv
rtl/tour_length_evaluator_top.sv
tb/tb.sv
